// ===== sv/hmh_pkg.sv =====
`default_nettype none
package hmh_pkg;

    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_MAX_HANDLES = 1024;

    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_PEEK     = 3'd1;
    localparam logic [2:0] ACT_DEL_MIN  = 3'd2;
    localparam logic [2:0] ACT_DEL_HDL  = 3'd3;
    localparam logic [2:0] ACT_CHG_HDL  = 3'd4;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_EMPTY      = 2'd1;
    localparam logic [1:0] STAT_NO_HANDLE  = 2'd2;
    localparam logic [1:0] STAT_BAD_HANDLE = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] new_value;
        logic [10:0]        handle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic [10:0]        heap_size;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_LK, S_RM_A, S_RM_B, S_RM_C,
        S_D0, S_D1, S_D2, S_D3, S_U0, S_U1, S_FIN, S_RESP
    } t_state;

endpackage
`default_nettype wire

// ===== sv/hmh_ram.sv =====
`default_nettype none
module hmh_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1025,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/indexed_min_heap_unit.sv =====
`default_nettype none
// Indexed binary min-heap of signed 32-bit values. Raise start with an action beat on i_item
// while busy is low; the beat is taken at that edge and busy stays high until the result has
// been shown. The result appears on o_result for exactly one cycle, marked by o_done, and cannot
// be held off, so capture it on that cycle. Handles count up from 1 in insertion order and are
// never reused. Peek, unknown actions and beats refused at decode go straight to the result, and
// a handle can also be refused after its lookup. An inserted entry rises level by level from the
// new last leaf, and deletes and changes let the entry sink or rise level by level. The sift loop
// is paced by the single read port of the value and owner memories. No memory clearing pass is
// needed after reset: handles above the issued count are refused before their position entry
// is ever used.
module indexed_min_heap_unit #(
    parameter int CAPACITY    = hmh_pkg::DEF_CAPACITY,
    parameter int MAX_HANDLES = hmh_pkg::DEF_MAX_HANDLES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire hmh_pkg::t_in  i_item,
    output logic               busy,
    output logic               o_done,
    output hmh_pkg::t_out      o_result
);
    import hmh_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int HW = $clog2(MAX_HANDLES + 1);

    t_state r_state, n_state;
    t_in    r_in, n_in;
    logic [PW-1:0] r_pos, n_pos, r_m, n_m, r_live, n_live;
    logic [HW-1:0] r_issued, n_issued, r_cur_own, n_cur_own, r_cown, n_cown, r_dead, n_dead;
    logic signed [31:0] r_cur_val, n_cur_val, r_cval, n_cval, r_min, n_min;
    logic [1:0] r_status, n_status;

    // memory ports
    logic          v_we;
    logic [PW-1:0] v_waddr, rd_addr;
    logic [31:0]   v_wdata, v_q;
    logic [HW-1:0] o_wdata, o_q;
    logic          h_we;
    logic [HW-1:0] h_waddr, h_raddr;
    logic [PW-1:0] h_wdata, h_q;

    // shared compare unit
    logic signed [31:0] cmp_a, cmp_b;
    logic               cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    logic [PW:0] l_pos, r_child;
    assign l_pos   = {r_pos, 1'b0};
    assign r_child = {r_pos, 1'b1};

    logic [HW-1:0] h_idx;
    assign h_idx = HW'(r_in.handle);

    logic full;
    assign full = (r_issued >= HW'(MAX_HANDLES)) || (r_live >= PW'(CAPACITY));

    hmh_ram #(.W(32), .DEPTH(CAPACITY + 1), .AW(PW)) u_val (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(rd_addr), .o_rdata(v_q)
    );
    hmh_ram #(.W(HW), .DEPTH(CAPACITY + 1), .AW(PW)) u_own (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(o_wdata),
        .i_raddr(rd_addr), .o_rdata(o_q)
    );
    hmh_ram #(.W(PW), .DEPTH(MAX_HANDLES + 1), .AW(HW)) u_hpos (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_DEC;
            S_DEC: begin
                case (r_in.action)
                    ACT_INSERT:  n_state = full ? S_RESP : S_U0;
                    ACT_DEL_MIN: n_state = (r_live == '0) ? S_RESP : S_RM_A;
                    ACT_DEL_HDL, ACT_CHG_HDL: begin
                        if (r_in.handle == '0 || r_in.handle > 11'(r_issued)) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_LK;
                        end
                    end
                    default:     n_state = S_RESP;
                endcase
            end
            S_LK: begin
                if (h_q == '0 || h_q > r_live) begin
                    n_state = S_RESP;
                end else if (r_in.action == ACT_CHG_HDL) begin
                    n_state = S_D0;
                end else begin
                    n_state = S_RM_A;
                end
            end
            S_RM_A: n_state = S_RM_B;
            S_RM_B: n_state = S_RM_C;
            S_RM_C: n_state = (r_pos == r_live) ? S_RESP : S_D0;
            S_D0:   n_state = (l_pos > {1'b0, r_live}) ? S_U0 : S_D1;
            S_D1:   n_state = (r_child <= {1'b0, r_live}) ? S_D2 : S_D3;
            S_D2:   n_state = S_D3;
            S_D3:   n_state = cmp_lt ? S_D0 : S_U0;
            S_U0:   n_state = (r_pos == PW'(1)) ? S_FIN : S_U1;
            S_U1:   n_state = cmp_lt ? S_U0 : S_FIN;
            S_FIN:  n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_in      = r_in;
        n_pos     = r_pos;
        n_m       = r_m;
        n_live    = r_live;
        n_issued  = r_issued;
        n_cur_val = r_cur_val;
        n_cur_own = r_cur_own;
        n_cval    = r_cval;
        n_cown    = r_cown;
        n_dead    = r_dead;
        n_status  = r_status;
        v_we      = 1'b0;
        v_waddr   = r_pos;
        v_wdata   = r_cur_val;
        o_wdata   = r_cur_own;
        h_we      = 1'b0;
        h_waddr   = r_cur_own;
        h_wdata   = r_pos;
        h_raddr   = h_idx;
        rd_addr   = r_pos;
        cmp_a     = r_cval;
        cmp_b     = r_cur_val;
        case (r_state)
            S_IDLE: if (start) n_in = i_item;
            S_DEC: begin
                n_status = STAT_OK;
                case (r_in.action)
                    ACT_INSERT: begin
                        if (full) begin
                            n_status = STAT_NO_HANDLE;
                        end else begin
                            n_issued  = HW'(r_issued + 1'b1);
                            n_live    = PW'(r_live + 1'b1);
                            n_pos     = PW'(r_live + 1'b1);
                            n_cur_val = r_in.new_value;
                            n_cur_own = HW'(r_issued + 1'b1);
                        end
                    end
                    ACT_PEEK:    if (r_live == '0) n_status = STAT_EMPTY;
                    ACT_DEL_MIN: begin
                        if (r_live == '0) n_status = STAT_EMPTY;
                        n_pos = PW'(1);
                    end
                    ACT_DEL_HDL, ACT_CHG_HDL: begin
                        if (r_in.handle == '0 || r_in.handle > 11'(r_issued)) begin
                            n_status = STAT_BAD_HANDLE;
                        end
                    end
                    default: ;
                endcase
            end
            S_LK: begin
                n_pos     = h_q;
                n_cur_val = r_in.new_value;
                n_cur_own = h_idx;
                if (h_q == '0 || h_q > r_live) n_status = STAT_BAD_HANDLE;
            end
            S_RM_B: begin
                n_dead  = o_q;
                rd_addr = r_live;
            end
            S_RM_C: begin
                // retire the removed handle, carry the last entry into the hole
                h_we      = 1'b1;
                h_waddr   = r_dead;
                h_wdata   = '0;
                n_cur_val = v_q;
                n_cur_own = o_q;
                n_live    = PW'(r_live - 1'b1);
            end
            S_D0: begin
                rd_addr = l_pos[PW-1:0];
                n_m     = l_pos[PW-1:0];
            end
            S_D1: begin
                n_cval  = v_q;
                n_cown  = o_q;
                rd_addr = r_child[PW-1:0];
            end
            S_D2: begin
                cmp_a = r_cval;
                cmp_b = v_q;
                if (!cmp_lt) begin
                    n_cval = v_q;
                    n_cown = o_q;
                    n_m    = PW'(r_m + 1'b1);
                end
            end
            S_D3: begin
                cmp_a = r_cval;
                cmp_b = r_cur_val;
                if (cmp_lt) begin
                    // lift the smaller child into the hole
                    v_we    = 1'b1;
                    v_wdata = r_cval;
                    o_wdata = r_cown;
                    h_we    = 1'b1;
                    h_waddr = r_cown;
                    n_pos   = r_m;
                end
            end
            S_U0: rd_addr = r_pos >> 1;
            S_U1: begin
                cmp_a = r_cur_val;
                cmp_b = v_q;
                if (cmp_lt) begin
                    // drop the parent into the hole
                    v_we    = 1'b1;
                    v_wdata = v_q;
                    o_wdata = o_q;
                    h_we    = 1'b1;
                    h_waddr = o_q;
                    n_pos   = r_pos >> 1;
                end
            end
            S_FIN: begin
                v_we = 1'b1;
                h_we = 1'b1;
            end
            default: ;
        endcase
    end

    // mirror the root value
    always_comb begin
        n_min = r_min;
        if (v_we && v_waddr == PW'(1)) n_min = v_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= '0;
            r_issued <= '0;
        end else begin
            r_state  <= n_state;
            r_live   <= n_live;
            r_issued <= n_issued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_pos     <= n_pos;
        r_m       <= n_m;
        r_cur_val <= n_cur_val;
        r_cur_own <= n_cur_own;
        r_cval    <= n_cval;
        r_cown    <= n_cown;
        r_dead    <= n_dead;
        r_status  <= n_status;
        r_min     <= n_min;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_done              = (r_state == S_RESP);
    assign o_result.min_value  = (r_live != '0) ? r_min : 32'sd0;
    assign o_result.heap_size  = 11'(r_live);
    assign o_result.status     = r_status;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat outside a busy window");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done)) else $error("accepted beat not taken up");
    a_live_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= PW'(CAPACITY)) else $error("live count beyond capacity");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STAT_EMPTY) |-> (o_result.heap_size == '0))
        else $error("empty status with live entries");
    a_live_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_live)) else $error("live count moved while idle");
endmodule
`default_nettype wire
